// ----- design/dgp_pkg.sv -----
// Shared types, constants and helper functions for the digest-to-grid-path block.
`timescale 1ns / 1ps
package dgp_pkg;

	localparam int unsigned MaxResults = 12;
	localparam int unsigned MsgBytes   = 64;

	// Job handed from the front end to the back end: the 16 message words.
	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;
	typedef word_t [7:0]  chain_t;

	function automatic word_t sha_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t sha_iv(input logic [2:0] i);
		word_t v;
		case (i)
			3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// Neighbor count of a grid point (1..9).
	function automatic logic [3:0] grid_count(input logic [3:0] p);
		logic [3:0] c;
		case (p)
			4'd1, 4'd3, 4'd7, 4'd9: c = 4'd3;
			4'd5:                   c = 4'd8;
			default:                c = 4'd5;
		endcase
		return c;
	endfunction

	// Neighbor number j (0-based) of grid point p.
	function automatic logic [3:0] grid_link(input logic [3:0] p, input logic [2:0] j);
		logic [3:0] n;
		n = 4'd5;
		case (p)
			4'd1: case (j) 3'd0: n = 4'd2; 3'd1: n = 4'd4; default: n = 4'd5; endcase
			4'd2: case (j) 3'd0: n = 4'd1; 3'd1: n = 4'd3; 3'd2: n = 4'd4;
				3'd3: n = 4'd5; default: n = 4'd6; endcase
			4'd3: case (j) 3'd0: n = 4'd2; 3'd1: n = 4'd5; default: n = 4'd6; endcase
			4'd4: case (j) 3'd0: n = 4'd1; 3'd1: n = 4'd2; 3'd2: n = 4'd5;
				3'd3: n = 4'd7; default: n = 4'd8; endcase
			4'd5: case (j) 3'd0: n = 4'd1; 3'd1: n = 4'd2; 3'd2: n = 4'd3;
				3'd3: n = 4'd4; 3'd4: n = 4'd6; 3'd5: n = 4'd7;
				3'd6: n = 4'd8; default: n = 4'd9; endcase
			4'd6: case (j) 3'd0: n = 4'd2; 3'd1: n = 4'd3; 3'd2: n = 4'd5;
				3'd3: n = 4'd8; default: n = 4'd9; endcase
			4'd7: case (j) 3'd0: n = 4'd4; 3'd1: n = 4'd5; default: n = 4'd8; endcase
			4'd8: case (j) 3'd0: n = 4'd4; 3'd1: n = 4'd5; 3'd2: n = 4'd6;
				3'd3: n = 4'd7; default: n = 4'd9; endcase
			4'd9: case (j) 3'd0: n = 4'd5; 3'd1: n = 4'd6; default: n = 4'd8; endcase
			default: n = 4'd5;
		endcase
		return n;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- design/dgp_front.sv -----
// Front end: packs message bytes into a 16-word block and hands it over.
`timescale 1ns / 1ps
module dgp_front
	import dgp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] message_byte,
	output logic       blk_valid,
	input  logic       blk_take,
	output block_t     blk_data
);

	logic [5:0] byte_cnt_q;
	block_t     words_q;
	logic       full_q;

	// Hold input while a finished block waits in the queue slot.
	assign in_stall  = full_q;
	assign blk_valid = full_q;
	assign blk_data  = words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			full_q     <= 1'b0;
		end else begin
			if (in_valid && !full_q) begin
				byte_cnt_q <= byte_cnt_q + 6'd1;
				if (byte_cnt_q == 6'd63) full_q <= 1'b1;
			end else if (blk_take) begin
				full_q <= 1'b0;
			end
		end
	end

	// Shift each byte into its big-endian word.
	always_ff @(posedge clk) begin
		if (in_valid && !full_q)
			words_q[byte_cnt_q[5:2]] <= {words_q[byte_cnt_q[5:2]][23:0], message_byte};
	end

endmodule

// ----- design/dgp_back.sv -----
// Back end: two SHA-256 compressions, serial modular reduction, grid walk.
`timescale 1ns / 1ps
module dgp_back
	import dgp_pkg::*;
#(
	parameter int unsigned MW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [MW-1:0] modulus,
	input  logic          blk_valid,
	output logic          blk_take,
	input  block_t        blk_data,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [3:0]    path_point,
	output logic          final_point
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_HASH = 7'b0000010,
		S_ADD  = 7'b0000100,
		S_RED  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	localparam int unsigned PW = MW + 4;

	state_t        state_q;
	block_t        w_q;
	chain_t        h_q, v_q;
	logic [5:0]    rnd_q;
	logic          pass_q;
	logic [4:0]    bcnt_q;
	logic [MW-1:0] mod_q, id_q;
	logic [PW-1:0] rem_q;
	logic [3:0]    quo_q;
	logic [2:0]    dcnt_q;
	logic [PW+3:0] radix_q;
	logic [3:0]    cur_q;
	logic [3:0]    npts_q;
	logic          last_q;

	// Message schedule and round logic for one round per cycle.
	word_t s0, s1, w_new, t1, t2;
	assign s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + sha_k(rnd_q) + w_q[0];
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// Digest byte in big-endian order.
	logic [7:0] dbyte;
	word_t      dword;
	assign dword = h_q[bcnt_q[4:2]];
	always_comb begin
		case (bcnt_q[1:0])
			2'd0:    dbyte = dword[31:24];
			2'd1:    dbyte = dword[23:16];
			2'd2:    dbyte = dword[15:8];
			default: dbyte = dword[7:0];
		endcase
	end

	// Reduction: id*256+b < 256*mod, so reduce it one bit per cycle by restoring
	// shift-subtract over the 8 bits of each digest byte, msb first.
	logic [PW-1:0] mod_ext, trial;
	assign mod_ext = PW'(mod_q);
	assign trial   = {rem_q[PW-2:0], 1'b0};

	// Path step: id*count < 8*mod, quotient bits by compare-subtract
	// against mod<<3, mod<<2, mod<<1, mod, one step a cycle.
	logic [PW-1:0] div_sh, div_rem;
	logic          div_ge;
	logic [3:0]    quo_nx;
	assign div_sh  = mod_ext << (2'd3 - dcnt_q[1:0]);
	assign div_ge  = rem_q >= div_sh;
	assign div_rem = div_ge ? rem_q - div_sh : rem_q;
	assign quo_nx  = {quo_q[2:0], div_ge};

	logic [3:0] cnt_now;
	assign cnt_now = grid_count(cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_take <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			blk_take <= (state_q == S_IDLE) && blk_valid && !blk_take;
			case (state_q)
				S_IDLE: if (blk_valid && !blk_take) state_q <= S_HASH;
				S_HASH: if (rnd_q == 6'd63) state_q <= S_ADD;
				S_ADD: state_q <= pass_q ? S_RED : S_HASH;
				S_RED: if (bcnt_q == 5'd31 && dcnt_q == 3'd7) state_q <= S_EMIT;
				S_EMIT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					state_q   <= last_q ? S_IDLE : S_MUL;
				end
				S_MUL: if (!out_valid || !out_stall) state_q <= S_DIV;
				S_DIV: if (dcnt_q == 3'd3) state_q <= S_EMIT;
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && !out_stall && !(state_q == S_EMIT))
				out_valid <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q    <= blk_data;
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= sha_iv(3'(i));
					v_q[i] <= sha_iv(3'(i));
				end
				rnd_q  <= '0;
				pass_q <= 1'b0;
				mod_q  <= (modulus == '0) ? MW'(1) : modulus;
			end
			S_HASH: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q <= {v_q[6], v_q[5], v_q[4], v_q[3] + t1,
					v_q[2], v_q[1], v_q[0], t1 + t2};
				rnd_q <= rnd_q + 6'd1;
			end
			S_ADD: begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
					v_q[i] <= h_q[i] + v_q[i];
				end
				for (int i = 0; i < 16; i++) w_q[i] <= '0;
				w_q[0]  <= 32'h80000000;
				w_q[15] <= 32'd512;
				pass_q  <= 1'b1;
				bcnt_q  <= '0;
				dcnt_q  <= '0;
				rem_q   <= '0;
			end
			S_RED: begin
				// Bit-serial: rem = (rem*2 + bit) mod m, bits of dbyte msb first.
				if ({1'b0, trial | PW'(dbyte[3'd7 - dcnt_q])} >= {1'b0, mod_ext})
					rem_q <= (trial | PW'(dbyte[3'd7 - dcnt_q])) - mod_ext;
				else
					rem_q <= trial | PW'(dbyte[3'd7 - dcnt_q]);
				dcnt_q <= dcnt_q + 3'd1;
				if (dcnt_q == 3'd7) bcnt_q <= bcnt_q + 5'd1;
				cur_q   <= 4'd5;
				radix_q <= (PW+4)'(1);
				npts_q  <= 4'd1;
				last_q  <= (mod_q == MW'(1));
			end
			S_EMIT: if (!out_valid || !out_stall) begin
				path_point  <= cur_q;
				final_point <= last_q;
				if (npts_q == 4'd1) id_q <= rem_q[MW-1:0];
			end
			S_MUL: begin
				rem_q  <= PW'(id_q) * PW'(cnt_now);
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				rem_q  <= div_rem;
				quo_q  <= quo_nx;
				dcnt_q <= dcnt_q + 3'd1;
				if (dcnt_q == 3'd3) begin
					cur_q   <= grid_link(cur_q, quo_nx[2:0]);
					radix_q <= radix_q * (PW+4)'(cnt_now);
					npts_q  <= npts_q + 4'd1;
					last_q  <= (radix_q * (PW+4)'(cnt_now) >= (PW+4)'(mod_q))
						|| (npts_q == 4'(MaxResults - 1));
					id_q    <= div_rem[MW-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/digest_to_grid_path_top.sv -----
// Top level of the digest-to-grid-path block.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall   | message_byte
//  out     | out | out_valid/out_stall | path_point, final_point
//  cfg     | in  | modulus_we          | modulus_wdata
// A message takes 64 accepted bytes, one per cycle at most; the 64th starts
// two 64-round compressions (one round a cycle), a bit-serial reduction of
// the 256-bit digest (one bit a cycle), then the walk that emits each path point.
// Reset clears control only; modulus resets to 27000.
// Input stalls while a full block waits for the back end.
`timescale 1ns / 1ps
module digest_to_grid_path_top
	import dgp_pkg::*;
#(
	parameter int unsigned MODULUS_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     modulus_we,
	input  logic [MODULUS_WIDTH-1:0] modulus_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               message_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [3:0]               path_point,
	output logic                     final_point
);

	logic [MODULUS_WIDTH-1:0] modulus_q;
	logic   blk_valid, blk_take;
	block_t blk_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= MODULUS_WIDTH'(27000);
		else if (modulus_we) modulus_q <= modulus_wdata;
	end

	dgp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .message_byte,
		.blk_valid, .blk_take, .blk_data
	);

	dgp_back #(.MW(MODULUS_WIDTH)) u_back (
		.clk, .arst_n, .modulus(modulus_q), .blk_valid, .blk_take, .blk_data,
		.out_valid, .out_stall, .path_point, .final_point
	);

endmodule

// ----- design/dgp_checker.sv -----
// Port-level checker for the digest-to-grid-path block, bound to the top.
`timescale 1ns / 1ps
module dgp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] path_point,
	input logic       final_point
);

	a_pt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (path_point != 4'd0 && path_point < 4'd10)) else $error("bad point");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(path_point)) else $error("payload moved");
	a_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && final_point |=> !out_valid || path_point == 4'd5)
		else $error("path restart");

endmodule

bind digest_to_grid_path_top dgp_checker u_chk (.*);

// ----- tb/sv/digest_to_grid_path_top_tb.sv -----
// Self-checking testbench for the digest-to-grid-path block: SHA-256 path predictor.
`timescale 1ns / 1ps
module digest_to_grid_path_top_tb;
	import dgp_pkg::*;

	localparam int unsigned MW = 16;
	localparam int unsigned WatchdogLimit = 10000;

	typedef struct packed {
		logic [3:0] point;
		logic       last;
	} path_step_t;

	logic          clk;
	logic          arst_n;
	logic          modulus_we;
	logic [MW-1:0] modulus_wdata;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [7:0]    message_byte = 8'h00;
	logic          out_valid;
	logic          out_stall = 1'b1;
	logic [3:0]    path_point;
	logic          final_point;

	digest_to_grid_path_top #(.MODULUS_WIDTH(MW)) dut (
		.clk(clk), .arst_n(arst_n),
		.modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .message_byte(message_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.path_point(path_point), .final_point(final_point)
	);

	// Predictor state
	logic [31:0]   msg_words [16] = '{default: '0};
	logic [31:0]   hash_state [8];
	int unsigned   bytes_seen = 0;
	logic [MW-1:0] cur_modulus = MW'(27000);

	logic [7:0]   byte_queue [$];
	path_step_t   path_queue [$];
	int           error_count = 0;
	int           idle_cycles = 0;
	bit           hold_receiver = 1'b0;
	int unsigned  hold_count = 0;
	logic         in_taken = 1'b0;
	int unsigned  send_gap = 0;
	int unsigned  stall_run = 0;
	path_step_t   want;

	// Grid tables
	function automatic int unsigned link_count(int unsigned p);
		case (p)
			1, 3, 7, 9: return 3;
			5:          return 8;
			default:    return 5;
		endcase
	endfunction

	function automatic int unsigned link_to(int unsigned p, int unsigned j);
		int unsigned t1 [3] = '{2, 4, 5};
		int unsigned t2 [5] = '{1, 3, 4, 5, 6};
		int unsigned t3 [3] = '{2, 5, 6};
		int unsigned t4 [5] = '{1, 2, 5, 7, 8};
		int unsigned t5 [8] = '{1, 2, 3, 4, 6, 7, 8, 9};
		int unsigned t6 [5] = '{2, 3, 5, 8, 9};
		int unsigned t7 [3] = '{4, 5, 8};
		int unsigned t8 [5] = '{4, 5, 6, 7, 9};
		int unsigned t9 [3] = '{5, 6, 8};
		case (p)
			1: return t1[j]; 2: return t2[j]; 3: return t3[j];
			4: return t4[j]; 5: return t5[j]; 6: return t6[j];
			7: return t7[j]; 8: return t8[j]; default: return t9[j];
		endcase
	endfunction

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One SHA-256 compression over a 16-word block into hash_state
	task automatic sha_compress(input logic [31:0] blk [16]);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(i[5:0]) + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	// Accept one message byte; on the 64th, queue the whole expected path
	task automatic absorb_byte(input logic [7:0] b);
		logic [31:0]    pad [16];
		longint unsigned m, id, prod;
		int unsigned     cur, nc, n;
		path_step_t      s;
		msg_words[bytes_seen / 4] = {msg_words[bytes_seen / 4][23:0], b};
		bytes_seen++;
		if (bytes_seen < MsgBytes) return;
		for (int i = 0; i < 8; i++) hash_state[i] = sha_iv(i[2:0]);
		sha_compress(msg_words);
		for (int i = 0; i < 16; i++) pad[i] = 32'h0;
		pad[0]  = 32'h8000_0000;
		pad[15] = 32'd512;
		sha_compress(pad);
		m = (cur_modulus == 0) ? 1 : cur_modulus;
		id = 0;
		for (int i = 0; i < 32; i++)
			id = (id * 256 + ((hash_state[i / 4] >> (24 - 8 * (i % 4))) & 8'hff)) % m;
		cur = 5;
		prod = 1;
		n = 0;
		while (prod < m && n < MaxResults - 1) begin
			s.point = cur[3:0];
			s.last  = 1'b0;
			path_queue = {path_queue, s};
			n++;
			nc = link_count(cur);
			cur = link_to(cur, int'((id * nc) / m));
			prod *= nc;
			id = (id * nc) % m;
		end
		s.point = cur[3:0];
		s.last  = 1'b1;
		path_queue = {path_queue, s};
		bytes_seen = 0;
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch: %s at %0t", what, $realtime);
		error_count++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample of the input handshake at the rising edge; feeds the predictor
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			absorb_byte(message_byte);
	end

	// Sender: hold a stalled transaction, else send the next byte or idle
	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (byte_queue.size() != 0) begin
				in_valid     <= 1'b1;
				message_byte <= byte_queue.pop_front();
				send_gap     <= ($urandom_range(0, 3) != 0) ? 0
					: (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
					: $urandom_range(1, 3));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with a forced long hold-off
	always @(negedge clk) begin
		if (hold_receiver) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else if (stall_run != 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compare each path transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (path_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected point %0d", path_point));
			end else begin
				want = path_queue.pop_front();
				if (path_point !== want.point)
					report_mismatch($sformatf("point got %0d want %0d", path_point,
						want.point));
				if (final_point !== want.last)
					report_mismatch($sformatf("final got %0b want %0b", final_point,
						want.last));
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_message(input int kind);
		for (int i = 0; i < MsgBytes; i++) begin
			case (kind)
				0: byte_queue = {byte_queue, 8'h00};
				1: byte_queue = {byte_queue, 8'hff};
				2: byte_queue = {byte_queue, ((i % 2) ? 8'haa : 8'h55)};
				default: byte_queue = {byte_queue, 8'($urandom_range(0, 255))};
			endcase
		end
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || in_valid || path_queue.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [MW-1:0] v);
		@(negedge clk);
		modulus_we    <= 1'b1;
		modulus_wdata <= v;
		@(negedge clk);
		modulus_we <= 1'b0;
		cur_modulus = v;
	endtask

	initial begin
		arst_n        = 1'b0;
		modulus_we    = 1'b0;
		modulus_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Receiver hold-off while three whole messages are queued at the reset
		// modulus so the input backs up, all-zero and 55/aa byte values included
		hold_receiver = 1'b1;
		queue_message(0);
		queue_message(2);
		queue_message(3);
		while (hold_count < 600) @(posedge clk);
		hold_receiver = 1'b0;
		drain();

		// Modulus zero acts as one: a single final point
		write_modulus(MW'(0));
		queue_message(1);
		drain();

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
